// ----- hdl/assert_macros.svh -----
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked through reset as well
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/lcdns_pkg.sv -----
package lcdns_pkg;

   localparam int PW_W        = 10;
   localparam int HOLD_W      = 18;
   localparam int QUEUE_DEPTH = 2;
   localparam int INIT_PIECES = 11;
   localparam int PIECE_IDX_W = 4;
   localparam int STEP_W      = 3;

   localparam logic [PW_W-1:0] PW_RESET = 10'd50;

   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_HOME         = 8'h02;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
   localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
   localparam logic [3:0] WAKE_NIBBLE      = 4'h3;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] value;
      logic [5:0] column;
      logic [1:0] row;
   } req_type;

   typedef struct packed {
      logic              reg_select;
      logic              enable;
      logic [3:0]        nibble;
      logic [HOLD_W-1:0] hold_us;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_INIT    = 3'd0,
      OP_COMMAND = 3'd1,
      OP_DATA    = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_CURSOR  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      HOLD_ZERO,
      HOLD_PULSE,
      HOLD_1MS,
      HOLD_2MS,
      HOLD_3MS,
      HOLD_4MS,
      HOLD_POWER
   } hold_type;

   typedef enum logic [1:0] {
      PIECE_POWER,
      PIECE_WAKE,
      PIECE_BYTE
   } piece_kind_type;

   typedef struct packed {
      piece_kind_type kind;
      logic           reg_select;
      logic [7:0]     data_byte;
      hold_type       trail;
   } piece_type;

   typedef struct packed {
      logic      is_init;
      piece_type piece;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] row_base(input logic [1:0] row);
      logic [7:0] base;
      unique case (row)
         2'd0:    base = 8'h00;
         2'd1:    base = 8'h40;
         2'd2:    base = 8'h10;
         default: base = 8'h50;
      endcase
      return base;
   endfunction

   function automatic logic [HOLD_W-1:0] hold_value(input hold_type code,
                                                    input logic [PW_W-1:0] pw);
      logic [HOLD_W-1:0] v;
      unique case (code)
         HOLD_ZERO:  v = '0;
         HOLD_PULSE: v = HOLD_W'(pw);
         HOLD_1MS:   v = 18'd1000;
         HOLD_2MS:   v = 18'd2000;
         HOLD_3MS:   v = 18'd3000;
         HOLD_4MS:   v = 18'd4000;
         HOLD_POWER: v = 18'd200000;
         default:    v = '0;
      endcase
      return v;
   endfunction

   function automatic piece_type make_byte(input logic [7:0] b, input hold_type trail);
      piece_type p;
      p.kind       = PIECE_BYTE;
      p.reg_select = 1'b0;
      p.data_byte  = b;
      p.trail      = trail;
      return p;
   endfunction

   // power-up script: hold, three wake nibbles, fixed set-up commands, clear
   function automatic piece_type init_piece(input logic [PIECE_IDX_W-1:0] idx);
      piece_type p;
      p = '{kind: PIECE_POWER, reg_select: 1'b0, data_byte: 8'h00, trail: HOLD_ZERO};
      unique case (idx) inside
         4'd0:             p.kind = PIECE_POWER;
         4'd1, 4'd2, 4'd3: p.kind = PIECE_WAKE;
         4'd4, 4'd5:       p = make_byte(CMD_FUNCTION_SET, HOLD_1MS);
         4'd6:             p = make_byte(CMD_DISPLAY_ON, HOLD_1MS);
         4'd7:             p = make_byte(CMD_CLEAR, HOLD_2MS);
         4'd8:             p = make_byte(CMD_ENTRY_MODE, HOLD_1MS);
         4'd9:             p = make_byte(CMD_HOME, HOLD_2MS);
         4'd10:            p = make_byte(CMD_CLEAR, HOLD_4MS);
         default:          p.kind = PIECE_POWER;
      endcase
      return p;
   endfunction

   function automatic logic [STEP_W-1:0] piece_last_step(input piece_kind_type kind);
      logic [STEP_W-1:0] s;
      unique case (kind)
         PIECE_POWER: s = 3'd0;
         PIECE_WAKE:  s = 3'd2;
         default:     s = 3'd4;
      endcase
      return s;
   endfunction

endpackage

// ----- hdl/lcdns_front.sv -----
module lcdns_front (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lcdns_pkg::req_type        req_payload,
   input  lcdns_pkg::queue_status_type queue_status,
   output logic                      push,
   output lcdns_pkg::job_type        push_job
);
   import lcdns_pkg::*;

   logic       known_op;
   logic [7:0] cursor_addr;

   // row base and column are added within the byte before the set-address bit goes on
   assign cursor_addr = (row_base(req_payload.row) + {2'b00, req_payload.column})
                        | CMD_SET_DDRAM;

   always_comb begin
      known_op = 1'b1;
      push_job = '{is_init: 1'b0, piece: make_byte(req_payload.value, HOLD_ZERO)};
      unique case (op_type'(req_payload.operation))
         OP_INIT: begin
            push_job.is_init = 1'b1;
         end
         OP_COMMAND: begin
            push_job.piece = make_byte(req_payload.value, HOLD_ZERO);
         end
         OP_DATA: begin
            push_job.piece            = make_byte(req_payload.value, HOLD_PULSE);
            push_job.piece.reg_select = 1'b1;
         end
         OP_CLEAR: begin
            push_job.piece = make_byte(CMD_CLEAR, HOLD_4MS);
         end
         OP_CURSOR: begin
            push_job.piece = make_byte(cursor_addr, HOLD_3MS);
         end
         default: begin
            known_op = 1'b0;
         end
      endcase
   end

   // unused codes are taken and dropped
   assign req_ready = !queue_status.full;
   assign push      = req_valid && !queue_status.full && known_op;

endmodule

// ----- hdl/lcdns_queue.sv -----
module lcdns_queue #(
   parameter int DEPTH = lcdns_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  lcdns_pkg::job_type          push_job,
   input  logic                        pop,
   output lcdns_pkg::job_type          head_job,
   output lcdns_pkg::queue_status_type status
);
   import lcdns_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hdl/lcdns_back.sv -----
module lcdns_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [lcdns_pkg::PW_W-1:0]   pulse_width,
   input  lcdns_pkg::job_type           head_job,
   input  lcdns_pkg::queue_status_type  queue_status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lcdns_pkg::rsp_type           rsp_payload
);
   import lcdns_pkg::*;

   logic                   busy_ff, busy_in;
   job_type                job_ff, job_in;
   logic [PIECE_IDX_W-1:0] idx_ff, idx_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   job_type                cur_job;
   logic [PIECE_IDX_W-1:0] cur_idx;
   logic [STEP_W-1:0]      cur_step;
   piece_type              piece;
   logic                   emit, step_end, piece_end;
   logic [3:0]             nib;
   logic                   en;
   hold_type               hold_code;

   // when idle the head of the queue starts playing in the same cycle
   assign cur_job   = busy_ff ? job_ff : head_job;
   assign cur_idx   = busy_ff ? idx_ff : '0;
   assign cur_step  = busy_ff ? step_ff : '0;
   assign piece     = cur_job.is_init ? init_piece(cur_idx) : cur_job.piece;
   assign emit      = (busy_ff || !queue_status.empty) && (!rsp_valid_ff || rsp_ready);
   assign pop       = emit && !busy_ff;
   assign step_end  = (cur_step == piece_last_step(piece.kind));
   assign piece_end = !cur_job.is_init || (cur_idx == PIECE_IDX_W'(INIT_PIECES - 1));

   always_comb begin
      nib       = 4'h0;
      en        = 1'b0;
      hold_code = HOLD_ZERO;
      unique case (piece.kind)
         PIECE_POWER: begin
            hold_code = HOLD_POWER;
         end
         PIECE_WAKE: begin
            nib = WAKE_NIBBLE;
            en  = (cur_step == 3'd1);
            if (cur_step == 3'd1) begin
               hold_code = HOLD_PULSE;
            end else if (cur_step == 3'd2) begin
               hold_code = HOLD_1MS;
            end
         end
         PIECE_BYTE: begin
            // high nibble on steps 0 and 1, low nibble after
            nib = (cur_step < 3'd2) ? piece.data_byte[7:4] : piece.data_byte[3:0];
            en  = (cur_step == 3'd1) || (cur_step == 3'd3);
            if (en) begin
               hold_code = HOLD_PULSE;
            end else if (cur_step == 3'd4) begin
               hold_code = piece.trail;
            end
         end
         default: begin
            nib = 4'h0;
         end
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.reg_select  = piece.reg_select;
         rsp_in.enable      = en;
         rsp_in.nibble      = nib;
         rsp_in.hold_us     = hold_value(hold_code, pulse_width);
         rsp_in.last        = step_end && piece_end;
         job_in             = cur_job;
         if (step_end && piece_end) begin
            busy_in = 1'b0;
            idx_in  = '0;
            step_in = '0;
         end else if (step_end) begin
            busy_in = 1'b1;
            idx_in  = cur_idx + 1'b1;
            step_in = '0;
         end else begin
            busy_in = 1'b1;
            idx_in  = cur_idx;
            step_in = cur_step + 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- hdl/char_lcd_nibble_sequencer_core.sv -----
// Character LCD 4-bit bus sequencer. Each request is expanded into pin states (register
// select, enable, D7..D4 and a hold time in microseconds), one state per cycle while the
// result side keeps taking them: a command, character, clear or set-cursor request gives
// 5 pin states and init gives 45, paced by the back-end expander that produces one pin
// state a cycle into its output register. Unused operation codes are taken and give no
// result. A two-entry request queue sits in front of the expander, so further requests
// are taken while one is still playing out. The user must write the pulse width register
// (reset 50 us) through the csr port while the block is idle; nothing enforces this.
module char_lcd_nibble_sequencer_core #(
   parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lcdns_pkg::req_type         req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lcdns_pkg::rsp_type         rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [lcdns_pkg::PW_W-1:0] csr_write_data
);
   import lcdns_pkg::*;

   logic [PW_W-1:0]  pulse_width_ff;
   logic             push, pop;
   job_type          push_job, head_job;
   queue_status_type queue_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_width_ff <= PW_RESET;
      end else if (csr_write_enable) begin
         pulse_width_ff <= csr_write_data;
      end
   end

   lcdns_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .queue_status (queue_status),
      .push         (push),
      .push_job     (push_job)
   );

   lcdns_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   lcdns_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pulse_width  (pulse_width_ff),
      .head_job     (head_job),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

// ----- hdl/lcdns_checker.sv -----
`include "assert_macros.svh"

module lcdns_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input lcdns_pkg::rsp_type         rsp_payload,
   input logic                       csr_write_enable,
   input logic [lcdns_pkg::PW_W-1:0] csr_write_data
);
   import lcdns_pkg::*;

   // shadow of the pulse width as seen on the csr port
   logic [PW_W-1:0] pw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff <= PW_RESET;
      end else if (csr_write_enable) begin
         pw_ff <= csr_write_data;
      end
   end

   `ASSERT_NEXT_ALWAYS(a_idle_after_reset, clock, reset, !rsp_valid)

   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_payload))

   `ASSERT_IMP(a_strobe_hold, clock, reset, rsp_valid && rsp_payload.enable,
               rsp_payload.hold_us == HOLD_W'(pw_ff) && !rsp_payload.last)

   `ASSERT_IMP(a_data_ends_with_gap, clock, reset,
               rsp_valid && rsp_payload.reg_select && rsp_payload.last,
               !rsp_payload.enable && rsp_payload.hold_us == HOLD_W'(pw_ff))

endmodule

bind char_lcd_nibble_sequencer_core lcdns_checker u_checker (.*);

// ----- bench/char_lcd_nibble_sequencer_core_tb.sv -----
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_core_tb;
   import lcdns_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int OP_CODE_MAX  = 7;

   localparam logic [HOLD_W-1:0] POWER_UP_US = 18'd200000;
   localparam logic [HOLD_W-1:0] WAKE_GAP_US = 18'd1000;
   localparam logic [HOLD_W-1:0] CLEAR_US    = 18'd4000;
   localparam logic [HOLD_W-1:0] CURSOR_US   = 18'd3000;

   localparam logic [7:0] SETUP_CMDS [6] = '{CMD_FUNCTION_SET, CMD_FUNCTION_SET,
      CMD_DISPLAY_ON, CMD_CLEAR, CMD_ENTRY_MODE, CMD_HOME};
   localparam logic [HOLD_W-1:0] SETUP_GAPS [6] = '{18'd1000, 18'd1000, 18'd1000,
      18'd2000, 18'd1000, 18'd2000};
   localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h10, 8'h50};

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_write_enable;
   logic [PW_W-1:0]   csr_write_data;

   req_type           pending_requests[$];
   rsp_type           expected_pin_states[$];
   logic [PW_W-1:0]   pulse_width;
   logic              req_taken = 1'b0;
   int                send_idle_pct;
   int                recv_stall_pct;
   int                fail_count = 0;
   int                cycle_count = 0;

   char_lcd_nibble_sequencer_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic push_pin_state(input logic rs, input logic en, input logic [3:0] nib,
                                 input logic [HOLD_W-1:0] hold, input logic fin);
      rsp_type s;
      s.reg_select = rs;
      s.enable     = en;
      s.nibble     = nib;
      s.hold_us    = hold;
      s.last       = fin;
      expected_pin_states.push_back(s);
   endtask

   // high nibble then low, each strobed, then the trailing hold
   task automatic push_byte(input logic rs, input logic [7:0] b,
                            input logic [HOLD_W-1:0] trail, input logic fin);
      logic [HOLD_W-1:0] pw_hold;
      pw_hold = HOLD_W'(pulse_width);
      push_pin_state(rs, 1'b0, b[7:4], '0, 1'b0);
      push_pin_state(rs, 1'b1, b[7:4], pw_hold, 1'b0);
      push_pin_state(rs, 1'b0, b[3:0], '0, 1'b0);
      push_pin_state(rs, 1'b1, b[3:0], pw_hold, 1'b0);
      push_pin_state(rs, 1'b0, b[3:0], trail, fin);
   endtask

   task automatic expand_request(input req_type r);
      logic [7:0] cursor_addr;
      cursor_addr = (ROW_BASE[r.row] + {2'b00, r.column}) | CMD_SET_DDRAM;
      case (r.operation)
         OP_INIT: begin
            push_pin_state(1'b0, 1'b0, 4'h0, POWER_UP_US, 1'b0);
            for (int i = 0; i < 3; i++) begin
               push_pin_state(1'b0, 1'b0, WAKE_NIBBLE, '0, 1'b0);
               push_pin_state(1'b0, 1'b1, WAKE_NIBBLE, HOLD_W'(pulse_width), 1'b0);
               push_pin_state(1'b0, 1'b0, WAKE_NIBBLE, WAKE_GAP_US, 1'b0);
            end
            for (int i = 0; i < 6; i++)
               push_byte(1'b0, SETUP_CMDS[i], SETUP_GAPS[i], 1'b0);
            push_byte(1'b0, CMD_CLEAR, CLEAR_US, 1'b1);
         end
         OP_COMMAND: push_byte(1'b0, r.value, '0, 1'b1);
         OP_DATA:    push_byte(1'b1, r.value, HOLD_W'(pulse_width), 1'b1);
         OP_CLEAR:   push_byte(1'b0, CMD_CLEAR, CLEAR_US, 1'b1);
         OP_CURSOR:  push_byte(1'b0, cursor_addr, CURSOR_US, 1'b1);
         default: ;  // unused codes give no pin states
      endcase
   endtask

   function automatic req_type make_request(input logic [2:0] op, input logic [7:0] v,
                                            input logic [5:0] col, input logic [1:0] row);
      req_type r;
      r.operation = op;
      r.value     = v;
      r.column    = col;
      r.row       = row;
      return r;
   endfunction

   function automatic req_type random_request();
      int pick;
      logic [2:0] op;
      pick = $urandom_range(99);
      if (pick < 5)
         op = OP_INIT;
      else if (pick < 10)
         op = 3'($urandom_range(OP_CODE_MAX, int'(OP_CURSOR) + 1));
      else
         op = 3'($urandom_range(int'(OP_CURSOR), int'(OP_COMMAND)));
      return make_request(op, 8'($urandom_range(255)),
                          6'(($urandom_range(99) < 85) ? $urandom_range(39) : $urandom_range(63)),
                          2'($urandom_range(3)));
   endfunction

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // request side, driven on the falling edge
   always @(negedge clock) begin
      logic    next_valid;
      req_type next_payload;
      next_valid   = req_valid;
      next_payload = req_payload;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         next_valid = 1'b0;
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_payload = pending_requests.pop_front();
            next_valid   = 1'b1;
         end
      end
      req_valid   <= next_valid;
      req_payload <= next_payload;
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         expand_request(req_payload);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pin_states.size() == 0) begin
            $error("pin state with nothing expected: %p", rsp_payload);
            fail_count++;
         end else begin
            want = expected_pin_states.pop_front();
            compare_field("reg_select", want.reg_select, rsp_payload.reg_select);
            compare_field("enable", want.enable, rsp_payload.enable);
            compare_field("nibble", want.nibble, rsp_payload.nibble);
            compare_field("hold_us", want.hold_us, rsp_payload.hold_us);
            compare_field("last", want.last, rsp_payload.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // all requests taken, all pin states seen, then let any dud request drain
   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_valid || expected_pin_states.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_pulse_width(input logic [PW_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      pulse_width = v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random(input int count, input int send_pct, input int recv_pct);
      @(posedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) pending_requests.push_back(random_request());
      wait_idle();
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      pulse_width      = PW_RESET;
      send_idle_pct    = 9;
      recv_stall_pct   = 64;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed requests at the reset pulse width
      @(posedge clock);
      pending_requests.push_back(make_request(OP_INIT, 8'h00, 6'd0, 2'd0));
      pending_requests.push_back(make_request(OP_COMMAND, 8'h00, 6'd0, 2'd0));
      pending_requests.push_back(make_request(OP_COMMAND, 8'hFF, 6'd63, 2'd3));
      pending_requests.push_back(make_request(OP_COMMAND, 8'hA5, 6'd21, 2'd1));
      pending_requests.push_back(make_request(OP_DATA, 8'h00, 6'd0, 2'd0));
      pending_requests.push_back(make_request(OP_DATA, 8'hFF, 6'd0, 2'd0));
      pending_requests.push_back(make_request(OP_DATA, 8'h5A, 6'd42, 2'd2));
      pending_requests.push_back(make_request(OP_CLEAR, 8'hFF, 6'd63, 2'd3));
      pending_requests.push_back(make_request(OP_CURSOR, 8'h00, 6'd0, 2'd0));
      pending_requests.push_back(make_request(OP_CURSOR, 8'h00, 6'd39, 2'd1));
      pending_requests.push_back(make_request(OP_CURSOR, 8'hFF, 6'd17, 2'd2));
      pending_requests.push_back(make_request(OP_CURSOR, 8'h00, 6'd39, 2'd3));
      // columns past the display width; on row 3 the address carries into the top bit
      pending_requests.push_back(make_request(OP_CURSOR, 8'h00, 6'd63, 2'd3));
      pending_requests.push_back(make_request(OP_CURSOR, 8'h00, 6'd63, 2'd1));
      for (int op = int'(OP_CURSOR) + 1; op <= OP_CODE_MAX; op++)
         pending_requests.push_back(make_request(3'(op), 8'hFF, 6'd63, 2'd3));
      pending_requests.push_back(make_request(OP_DATA, 8'h81, 6'd5, 2'd0));
      wait_idle();

      write_pulse_width(10'd1);
      run_random(60, 9, 64);
      write_pulse_width(10'd1000);
      run_random(50, 9, 64);
      write_pulse_width(PW_W'($urandom_range(999, 2)));
      run_random(50, 64, 9);
      write_pulse_width(10'd0);
      run_random(40, 64, 9);
      write_pulse_width(10'd1023);
      run_random(40, 0, 0);
      write_pulse_width(PW_W'($urandom_range(1023)));
      run_random(40, 0, 0);

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
